/* design/wspd_pkg.sv */
// Package for the wall-selected PID differential drive block.
// Field widths, register indexes, reset values and shared types.
// No dependencies.
package wspd_pkg;

    // Default parameter values
    localparam int ERROR_WIDTH_DEF        = 16;
    localparam int SENSOR_WIDTH_DEF       = 12;
    localparam int GAIN_FRACTION_BITS_DEF = 12;

    // Fixed field widths
    localparam int BASE_WIDTH      = 15;
    localparam int THRESH_WIDTH    = 12;
    localparam int GAIN_WIDTH      = 16;
    localparam int SUM_WIDTH       = 32;
    localparam int DRIVE_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    // Register reset values (gains in Q4.12)
    localparam logic [GAIN_WIDTH-1:0] KP_RESET = 16'd2253;
    localparam logic [GAIN_WIDTH-1:0] KD_RESET = 16'd614;
    localparam logic [GAIN_WIDTH-1:0] KI_RESET = 16'd0;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_BASE_SPEED     = 3'd0,
        REG_LEFT_THRESHOLD = 3'd1,
        REG_RIGHT_THRESHOLD = 3'd2,
        REG_KP_GAIN        = 3'd3,
        REG_KD_GAIN        = 3'd4,
        REG_KI_GAIN        = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_BOTH  = 2'd3
    } wall_mode_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] kp;
        logic [GAIN_WIDTH-1:0] kd;
        logic [GAIN_WIDTH-1:0] ki;
    } pid_gains_t;

    typedef struct packed {
        logic [BASE_WIDTH-1:0]   base_speed;
        logic [THRESH_WIDTH-1:0] left_threshold;
        logic [THRESH_WIDTH-1:0] right_threshold;
        pid_gains_t              gains;
    } cfg_t;

endpackage

/* design/wall_select_pid_differential_drive.sv */
// Top level of the wall-selected PID differential drive steering block.
// Depends on wspd_pkg, wspd_cfg_regs and wspd_side_pid.
//
// Each request carries two front wall sensor levels and a left and right
// tracking error. A level at or above its threshold marks that wall present;
// the pair selects the mode (none, right only, left only, both). Each side in
// use computes trunc(kp*e) + trunc(kd*(e - prev)) + trunc(ki*sum'), where
// sum' is the 32-bit saturated running error sum, then stores e and sum'.
// Corrections are mixed around base_speed into two drives saturated to
// 16-bit signed; with no walls both drives are base_speed and no state moves.
// Gains are unsigned fixed point with GAIN_FRACTION_BITS fraction bits.
// Timing: one request per clock sustained while out_stall is low. A request
// taken is held in the input register until the result register is empty or
// being taken. One pass of compare, multiply and mix logic then feeds the
// result register, and the per-side previous-error and sum registers update
// on that same edge, so the next request sees the updated values. in_stall
// rises only when the input register is full and the result register is held
// by out_stall.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect on the
// next edge and are expected only while the block is idle.
module wall_select_pid_differential_drive
#(
    parameter int ERROR_WIDTH        = wspd_pkg::ERROR_WIDTH_DEF,
    parameter int SENSOR_WIDTH       = wspd_pkg::SENSOR_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = wspd_pkg::GAIN_FRACTION_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write_en,
    input  logic [wspd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [wspd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [SENSOR_WIDTH-1:0]               left_wall_level,
    input  logic [SENSOR_WIDTH-1:0]               right_wall_level,
    input  logic signed [ERROR_WIDTH-1:0]         left_error,
    input  logic signed [ERROR_WIDTH-1:0]         right_error,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [wspd_pkg::DRIVE_WIDTH-1:0] left_drive,
    output logic signed [wspd_pkg::DRIVE_WIDTH-1:0] right_drive,
    output logic [1:0]                            wall_mode
);

    localparam int DIFF_WIDTH = ERROR_WIDTH + 1;
    localparam int OPND_WIDTH = (DIFF_WIDTH > wspd_pkg::SUM_WIDTH) ?
                                DIFF_WIDTH : wspd_pkg::SUM_WIDTH;
    localparam int CORR_WIDTH = wspd_pkg::GAIN_WIDTH + 1 + OPND_WIDTH + 2;
    localparam int MIX_WIDTH  = CORR_WIDTH + 2;
    localparam int CMP_WIDTH  = (SENSOR_WIDTH > wspd_pkg::THRESH_WIDTH) ?
                                SENSOR_WIDTH : wspd_pkg::THRESH_WIDTH;
    localparam int DW         = wspd_pkg::DRIVE_WIDTH;
    localparam logic signed [MIX_WIDTH-1:0] DRV_MAX =
        MIX_WIDTH'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [MIX_WIDTH-1:0] DRV_MIN =
        MIX_WIDTH'(-(64'sd1 <<< (DW - 1)));

    wspd_pkg::cfg_t cfg;

    // input register
    logic                          s0_valid_reg;
    logic [SENSOR_WIDTH-1:0]       s0_left_level_reg;
    logic [SENSOR_WIDTH-1:0]       s0_right_level_reg;
    logic signed [ERROR_WIDTH-1:0] s0_left_err_reg;
    logic signed [ERROR_WIDTH-1:0] s0_right_err_reg;

    // result register
    logic                          out_valid_reg;
    logic signed [DW-1:0]          left_drive_reg;
    logic signed [DW-1:0]          right_drive_reg;
    wspd_pkg::wall_mode_t          wall_mode_reg;

    logic                          advance;
    logic                          in_take;
    logic                          left_wall;
    logic                          right_wall;
    wspd_pkg::wall_mode_t          mode_next;
    logic signed [CORR_WIDTH-1:0]  left_corr, right_corr;
    logic signed [MIX_WIDTH-1:0]   left_term, right_term, base_term;
    logic signed [MIX_WIDTH-1:0]   left_mix, right_mix;
    logic signed [DW-1:0]          left_drive_next, right_drive_next;

    wspd_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Handshake: the result register frees up when empty or being taken
    assign advance  = s0_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s0_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Wall detection and mode select
    assign left_wall  = CMP_WIDTH'(s0_left_level_reg) >= CMP_WIDTH'(cfg.left_threshold);
    assign right_wall = CMP_WIDTH'(s0_right_level_reg) >= CMP_WIDTH'(cfg.right_threshold);

    always_comb
    begin
        unique case ({left_wall, right_wall})
            2'b11:   mode_next = wspd_pkg::MODE_BOTH;
            2'b10:   mode_next = wspd_pkg::MODE_LEFT;
            2'b01:   mode_next = wspd_pkg::MODE_RIGHT;
            default: mode_next = wspd_pkg::MODE_NONE;
        endcase
    end

    // Per-side PID; state moves only when the side is active and the item advances
    wspd_side_pid #(
        .ERROR_WIDTH        (ERROR_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_left_pid (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance && left_wall),
        .err        (s0_left_err_reg),
        .gains      (cfg.gains),
        .correction (left_corr)
    );

    wspd_side_pid #(
        .ERROR_WIDTH        (ERROR_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_right_pid (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance && right_wall),
        .err        (s0_right_err_reg),
        .gains      (cfg.gains),
        .correction (right_corr)
    );

    // Differential mix: an inactive side contributes nothing
    assign base_term  = MIX_WIDTH'($signed({1'b0, cfg.base_speed}));
    assign left_term  = left_wall  ? MIX_WIDTH'(left_corr)  : '0;
    assign right_term = right_wall ? MIX_WIDTH'(right_corr) : '0;
    assign left_mix   = base_term + left_term - right_term;
    assign right_mix  = base_term - left_term + right_term;

    always_comb
    begin
        priority if (left_mix > DRV_MAX)
            left_drive_next = DW'(DRV_MAX);
        else if (left_mix < DRV_MIN)
            left_drive_next = DW'(DRV_MIN);
        else
            left_drive_next = left_mix[DW-1:0];

        priority if (right_mix > DRV_MAX)
            right_drive_next = DW'(DRV_MAX);
        else if (right_mix < DRV_MIN)
            right_drive_next = DW'(DRV_MIN);
        else
            right_drive_next = right_mix[DW-1:0];
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s0_valid_reg <= 1'b1;
            else if (advance)
                s0_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_left_level_reg  <= left_wall_level;
            s0_right_level_reg <= right_wall_level;
            s0_left_err_reg    <= left_error;
            s0_right_err_reg   <= right_error;
        end
        if (advance)
        begin
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
            wall_mode_reg   <= mode_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign wall_mode   = wall_mode_reg;

endmodule

/* design/wspd_cfg_regs.sv */
// Configuration register file for the wall-selected PID drive.
// Depends on wspd_pkg.
module wspd_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [wspd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [wspd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output wspd_pkg::cfg_t                        cfg
);

    wspd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed      <= '0;
            cfg_reg.left_threshold  <= '0;
            cfg_reg.right_threshold <= '0;
            cfg_reg.gains.kp        <= wspd_pkg::KP_RESET;
            cfg_reg.gains.kd        <= wspd_pkg::KD_RESET;
            cfg_reg.gains.ki        <= wspd_pkg::KI_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                wspd_pkg::REG_BASE_SPEED:
                    cfg_reg.base_speed <= cfg_data[wspd_pkg::BASE_WIDTH-1:0];
                wspd_pkg::REG_LEFT_THRESHOLD:
                    cfg_reg.left_threshold <= cfg_data[wspd_pkg::THRESH_WIDTH-1:0];
                wspd_pkg::REG_RIGHT_THRESHOLD:
                    cfg_reg.right_threshold <= cfg_data[wspd_pkg::THRESH_WIDTH-1:0];
                wspd_pkg::REG_KP_GAIN:
                    cfg_reg.gains.kp <= cfg_data[wspd_pkg::GAIN_WIDTH-1:0];
                wspd_pkg::REG_KD_GAIN:
                    cfg_reg.gains.kd <= cfg_data[wspd_pkg::GAIN_WIDTH-1:0];
                wspd_pkg::REG_KI_GAIN:
                    cfg_reg.gains.ki <= cfg_data[wspd_pkg::GAIN_WIDTH-1:0];
                default:
                    ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/wspd_side_pid.sv */
// One side's PID term with its previous-error and saturating error-sum state.
// Depends on wspd_pkg.
module wspd_side_pid
#(
    parameter int ERROR_WIDTH        = wspd_pkg::ERROR_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = wspd_pkg::GAIN_FRACTION_BITS_DEF,
    localparam int DIFF_WIDTH = ERROR_WIDTH + 1,
    localparam int OPND_WIDTH = (DIFF_WIDTH > wspd_pkg::SUM_WIDTH) ?
                                DIFF_WIDTH : wspd_pkg::SUM_WIDTH,
    localparam int PROD_WIDTH = wspd_pkg::GAIN_WIDTH + 1 + OPND_WIDTH,
    localparam int CORR_WIDTH = PROD_WIDTH + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic signed [ERROR_WIDTH-1:0] err,
    input  wspd_pkg::pid_gains_t          gains,
    output logic signed [CORR_WIDTH-1:0]  correction
);

    localparam int SW  = wspd_pkg::SUM_WIDTH;
    localparam int SXW = SW + 1; // error width is at most the sum width
    localparam int GSW = wspd_pkg::GAIN_WIDTH + 1;
    localparam logic signed [PROD_WIDTH-1:0] RND =
        PROD_WIDTH'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);

    logic signed [ERROR_WIDTH-1:0] prev_reg;
    logic signed [SW-1:0]          sum_reg;
    logic signed [SXW-1:0]         sum_ext;
    logic signed [SW-1:0]          sum_next;
    logic signed [DIFF_WIDTH-1:0]  diff;
    logic signed [GSW-1:0]         kp_s, kd_s, ki_s;
    logic signed [PROD_WIDTH-1:0]  p_kp, p_kd, p_ki;
    logic signed [PROD_WIDTH-1:0]  t_kp, t_kd, t_ki;

    // Truncate toward zero: bias negative products before the shift
    function automatic logic signed [PROD_WIDTH-1:0] trunc_q(
        input logic signed [PROD_WIDTH-1:0] p);
        logic signed [PROD_WIDTH-1:0] b;
        b = p + (p[PROD_WIDTH-1] ? RND : '0);
        return b >>> GAIN_FRACTION_BITS;
    endfunction

    always_comb
    begin
        sum_ext = SXW'(sum_reg) + SXW'(err);
        if (sum_ext[SXW-1] != sum_ext[SXW-2])
            sum_next = sum_ext[SXW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            sum_next = sum_ext[SW-1:0];
    end

    assign diff = DIFF_WIDTH'(err) - DIFF_WIDTH'(prev_reg);

    assign kp_s = $signed({1'b0, gains.kp});
    assign kd_s = $signed({1'b0, gains.kd});
    assign ki_s = $signed({1'b0, gains.ki});

    assign p_kp = PROD_WIDTH'(kp_s) * PROD_WIDTH'(err);
    assign p_kd = PROD_WIDTH'(kd_s) * PROD_WIDTH'(diff);
    assign p_ki = PROD_WIDTH'(ki_s) * PROD_WIDTH'(sum_next);

    assign t_kp = trunc_q(p_kp);
    assign t_kd = trunc_q(p_kd);
    assign t_ki = trunc_q(p_ki);

    assign correction = CORR_WIDTH'(t_kp) + CORR_WIDTH'(t_kd) + CORR_WIDTH'(t_ki);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            sum_reg  <= '0;
        end
        else if (update)
        begin
            prev_reg <= err;
            sum_reg  <= sum_next;
        end
    end

endmodule
